>>> sv/tpecf_pkg.sv
// ----------------------------------------------------------------------------
// tpecf_pkg
// Shared constants and state codes for the transparent pixel edge color fill.
// ----------------------------------------------------------------------------
package tpecf_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int CellSize  = 32;
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int AW        = XW + YW;
  localparam int CW        = $clog2(CellSize);
  localparam int DW        = 9;
  localparam int CountW    = 17;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [0:0] OpLoad = 1'b0;
  localparam logic [0:0] OpRead = 1'b1;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef logic [31:0] pixel_t;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StCenter = 4'd1;
  localparam logic [3:0] StCheck  = 4'd2;
  localparam logic [3:0] StCand   = 4'd3;
  localparam logic [3:0] StNbr    = 4'd4;
  localparam logic [3:0] StNbrWt  = 4'd5;
  localparam logic [3:0] StNext   = 4'd6;
  localparam logic [3:0] StOut    = 4'd7;
  localparam logic [3:0] StCandWt = 4'd8;

endpackage

>>> sv/transparent_pixel_edge_color_fill.sv
// ----------------------------------------------------------------------------
// transparent_pixel_edge_color_fill
// Pixel store with nearest edge color fill for transparent pixels on read.
// ----------------------------------------------------------------------------
// a load is taken every cycle while idle with no result held and no cfg_valid; an opaque,
// empty-image or out-of-range read goes through StCenter and StOut to its result, and
// no new request is taken until that result is accepted; a transparent read scans up to
// 96x96 candidates plus up to 8 neighbor reads each, all through the single store read port
// reset clears the opaque count and sets both dimensions to 256; the store
// keeps its contents, it is undefined until written.
module transparent_pixel_edge_color_fill (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] x_pos,
  input  logic [7:0] y_pos,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  output logic       in_range
);

  localparam int XW = tpecf_pkg::XW;
  localparam int YW = tpecf_pkg::YW;
  localparam int CW = tpecf_pkg::CW;
  localparam int DW = tpecf_pkg::DW;

  tpecf_pkg::pixel_t mem [tpecf_pkg::MaxWidth*tpecf_pkg::MaxHeight];
  tpecf_pkg::pixel_t rd_data;
  logic [tpecf_pkg::AW-1:0] rd_addr;
  logic                     rd_en;

  logic [DW-1:0] image_width, image_height;
  logic [tpecf_pkg::CountW-1:0] opaque_count;
  logic [3:0] state;

  // clamped dimensions, 1..max
  logic [DW-1:0] w_eff, h_eff;
  assign w_eff = (image_width == '0) ? DW'(1) :
                 (image_width > DW'(tpecf_pkg::MaxWidth)) ? DW'(tpecf_pkg::MaxWidth) : image_width;
  assign h_eff = (image_height == '0) ? DW'(1) :
                 (image_height > DW'(tpecf_pkg::MaxHeight)) ? DW'(tpecf_pkg::MaxHeight) :
                 image_height;

  logic inside_in;
  assign inside_in = ({1'b0, x_pos} < w_eff) && ({1'b0, y_pos} < h_eff);

  assign in_ready  = (state == tpecf_pkg::StIdle) && !out_valid && !cfg_valid;
  assign cfg_ready = (state == tpecf_pkg::StIdle) && !out_valid;

  logic in_acc, out_acc, cfg_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // read request
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  tpecf_pkg::pixel_t center;

  // cell scan: oy, ox in 0..2 for offsets -1..1
  logic [1:0] oy, ox;
  logic [CW-1:0] ly, lx;
  logic [3:0] nb;
  logic signed [DW+1:0] cxs, cys;   // candidate coordinates
  logic [31:0] best;
  logic [23:0] rgb;
  logic [23:0] cand_rgb;

  // cell geometry
  logic signed [DW+1:0] gx, gy, cell_x, cell_y;
  logic [DW-1:0] gw, gh;
  assign gx = (DW+2)'(px >> CW);
  assign gy = (DW+2)'(py >> CW);
  assign gw = DW'((w_eff + DW'(tpecf_pkg::CellSize - 1)) >> CW);
  assign gh = DW'((h_eff + DW'(tpecf_pkg::CellSize - 1)) >> CW);
  assign cell_x = gx + (DW+2)'(ox) - (DW+2)'(1);
  assign cell_y = gy + (DW+2)'(oy) - (DW+2)'(1);

  logic cell_ok;
  assign cell_ok = (cell_x >= 0) && (cell_y >= 0) &&
                   (cell_x < $signed({2'b0, gw})) && (cell_y < $signed({2'b0, gh}));

  logic signed [DW+1:0] cand_x, cand_y;
  assign cand_x = (cell_x <<< CW) + (DW+2)'(lx);
  assign cand_y = (cell_y <<< CW) + (DW+2)'(ly);
  logic cand_in;
  assign cand_in = (cand_x < $signed({2'b0, w_eff})) && (cand_y < $signed({2'b0, h_eff}));

  // neighbor of the candidate, center skipped
  logic signed [DW+1:0] nx, ny;
  logic [1:0] ndx, ndy;
  always_comb begin
    ndx = 2'd0;
    ndy = 2'd0;
    case (nb)
      4'd0: begin
        ndx = 2'd0;
        ndy = 2'd0;
      end
      4'd1: begin
        ndx = 2'd1;
        ndy = 2'd0;
      end
      4'd2: begin
        ndx = 2'd2;
        ndy = 2'd0;
      end
      4'd3: begin
        ndx = 2'd0;
        ndy = 2'd1;
      end
      4'd4: begin
        ndx = 2'd2;
        ndy = 2'd1;
      end
      4'd5: begin
        ndx = 2'd0;
        ndy = 2'd2;
      end
      4'd6: begin
        ndx = 2'd1;
        ndy = 2'd2;
      end
      4'd7: begin
        ndx = 2'd2;
        ndy = 2'd2;
      end
      default: ;
    endcase
    nx = cxs + (DW+2)'(ndx) - (DW+2)'(1);
    ny = cys + (DW+2)'(ndy) - (DW+2)'(1);
  end
  logic n_in;
  assign n_in = (nx >= 0) && (ny >= 0) && (nx < $signed({2'b0, w_eff})) &&
                (ny < $signed({2'b0, h_eff}));

  // squared distance, one multiplier pair on narrow values
  logic signed [DW+1:0] ddx, ddy;
  logic signed [2*DW+3:0] sqx, sqy;
  logic [31:0] d2;
  assign ddx = cxs - $signed({2'b0, 1'b0, px});
  assign ddy = cys - $signed({2'b0, 1'b0, py});
  assign sqx = ddx * ddx;
  assign sqy = ddy * ddy;
  assign d2  = 32'(sqx) + 32'(sqy);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = {py, px};
    case (state)
      tpecf_pkg::StIdle: begin
        rd_en = in_acc && (operation == tpecf_pkg::OpRead);
        rd_addr = {y_pos, x_pos};
      end
      tpecf_pkg::StCand: begin
        rd_en = 1'b1;
        rd_addr = {cand_y[YW-1:0], cand_x[XW-1:0]};
      end
      tpecf_pkg::StNbr: begin
        rd_en = n_in;
        rd_addr = {ny[YW-1:0], nx[XW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && operation == tpecf_pkg::OpLoad && inside_in)
      mem[{y_pos, x_pos}] <= {alpha_in, blue_in, green_in, red_in};
    if (rd_en)
      rd_data <= mem[rd_addr];
  end

  logic inr;
  logic last_cell_pix;
  assign last_cell_pix = (lx == CW'(tpecf_pkg::CellSize - 1)) &&
                         (ly == CW'(tpecf_pkg::CellSize - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpecf_pkg::StIdle;
      out_valid <= 1'b0;
      image_width <= DW'(256);
      image_height <= DW'(256);
      opaque_count <= '0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      if (cfg_acc) begin
        if (cfg_index == tpecf_pkg::RegWidth) begin
          image_width <= cfg_data;
          opaque_count <= '0;
        end else begin
          image_height <= cfg_data;
        end
      end
      case (state)
        tpecf_pkg::StIdle: begin
          if (in_acc) begin
            px <= x_pos;
            py <= y_pos;
            if (operation == tpecf_pkg::OpLoad) begin
              if (inside_in && alpha_in != 8'd0 && opaque_count != tpecf_pkg::CountMax)
                opaque_count <= opaque_count + 1'b1;
            end else begin
              inr <= inside_in;
              state <= tpecf_pkg::StCenter;
            end
          end
        end
        tpecf_pkg::StCenter: begin
          if (!inr) begin
            center <= '0;
            state <= tpecf_pkg::StOut;
          end else if (rd_data[31:24] != 8'd0 || opaque_count == '0) begin
            center <= rd_data;
            state <= tpecf_pkg::StOut;
          end else begin
            center <= rd_data;
            best <= 32'd1000000000;
            rgb <= '0;
            oy <= 2'd0; ox <= 2'd0; ly <= '0; lx <= '0;
            state <= tpecf_pkg::StCheck;
          end
        end
        tpecf_pkg::StCheck: begin
          // skip cells and pixels outside the grid or image
          if (!cell_ok || !cand_in) begin
            state <= tpecf_pkg::StNext;
          end else begin
            cxs <= cand_x;
            cys <= cand_y;
            state <= tpecf_pkg::StCand;
          end
        end
        tpecf_pkg::StCand: state <= tpecf_pkg::StCandWt;
        tpecf_pkg::StCandWt: begin
          cand_rgb <= rd_data[23:0];
          nb <= '0;
          state <= (rd_data[31:24] != 8'd0) ? tpecf_pkg::StNbr : tpecf_pkg::StNext;
        end
        tpecf_pkg::StNbr: begin
          if (!n_in) begin
            // out-of-image neighbor makes an edge
            if (d2 < best) begin
              best <= d2;
              rgb <= cand_rgb;
            end
            state <= tpecf_pkg::StNext;
          end else begin
            state <= tpecf_pkg::StNbrWt;
          end
        end
        tpecf_pkg::StNbrWt: begin
          if (rd_data[31:24] == 8'd0) begin
            if (d2 < best) begin
              best <= d2;
              rgb <= cand_rgb;
            end
            state <= tpecf_pkg::StNext;
          end else if (nb == 4'd7) begin
            state <= tpecf_pkg::StNext;
          end else begin
            nb <= nb + 4'd1;
            state <= tpecf_pkg::StNbr;
          end
        end
        tpecf_pkg::StNext: begin
          state <= tpecf_pkg::StCheck;
          if (!cell_ok || last_cell_pix) begin
            lx <= '0; ly <= '0;
            if (ox == 2'd2) begin
              ox <= 2'd0;
              if (oy == 2'd2) begin
                center <= {center[31:24], rgb};
                state <= tpecf_pkg::StOut;
              end else begin
                oy <= oy + 2'd1;
              end
            end else begin
              ox <= ox + 2'd1;
            end
          end else if (lx == CW'(tpecf_pkg::CellSize - 1)) begin
            lx <= '0;
            ly <= ly + 1'b1;
          end else begin
            lx <= lx + 1'b1;
          end
        end
        tpecf_pkg::StOut: begin
          out_valid <= 1'b1;
          red_out <= center[7:0];
          green_out <= center[15:8];
          blue_out <= center[23:16];
          alpha_out <= center[31:24];
          in_range <= inr;
          state <= tpecf_pkg::StIdle;
        end
        default: state <= tpecf_pkg::StIdle;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != tpecf_pkg::StIdle) |-> !in_ready) else $error("accept while busy");
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |-> (alpha_out == 8'd0 && red_out == 8'd0))
    else $error("out of range result not zero");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    (state == tpecf_pkg::StOut) |=> out_valid) else $error("result lost");
  a_count_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_acc && cfg_index == tpecf_pkg::RegWidth) |=> (opaque_count == '0))
    else $error("count not cleared");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the edge color fill block against a behavioral predictor of the
// pixel store and the nearest edge search. Each image in the random phases is filled
// completely before it is read, then reads and loads run under several idling phases.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       in_img;
  } fill_result_t;

  class fill_scoreboard;
    logic [31:0]  pixel_mem [0:65535];
    int unsigned  opaque_total;
    int unsigned  width_reg;
    int unsigned  height_reg;
    fill_result_t pending_q[$];
    int           errors;
    int           reads_checked;

    function new();
      opaque_total = 0;
      width_reg = 256;
      height_reg = 256;
      errors = 0;
      reads_checked = 0;
    endfunction

    function int dim(int unsigned v);
      if (v < 1) return 1;
      if (v > 256) return 256;
      return v;
    endfunction

    function void write_reg(logic [0:0] idx, logic [8:0] data);
      if (idx == tpecf_pkg::RegWidth) begin
        width_reg = 32'(data);
        opaque_total = 0;
      end else begin
        height_reg = 32'(data);
      end
    endfunction

    function bit is_opaque(int x, int y);
      if (x < 0 || y < 0 || x >= dim(width_reg) || y >= dim(height_reg)) return 0;
      return pixel_mem[y * tpecf_pkg::MaxWidth + x][31:24] != 0;
    endfunction

    function bit is_edge(int x, int y);
      if (!is_opaque(x, y)) return 0;
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++)
          if ((dx != 0 || dy != 0) && !is_opaque(x + dx, y + dy)) return 1;
      return 0;
    endfunction

    function logic [23:0] nearest_color(int px, int py);
      int w, h, gw, gh, cx, cy;
      longint best, d2;
      logic [23:0] color;
      w = dim(width_reg);
      h = dim(height_reg);
      gw = (w + tpecf_pkg::CellSize - 1) / tpecf_pkg::CellSize;
      gh = (h + tpecf_pkg::CellSize - 1) / tpecf_pkg::CellSize;
      best = 1000000000;
      color = '0;
      for (int oy = -1; oy <= 1; oy++)
        for (int ox = -1; ox <= 1; ox++) begin
          cx = px / tpecf_pkg::CellSize + ox;
          cy = py / tpecf_pkg::CellSize + oy;
          if (cx < 0 || cy < 0 || cx >= gw || cy >= gh) continue;
          for (int y = cy * tpecf_pkg::CellSize;
               y < (cy + 1) * tpecf_pkg::CellSize && y < h; y++)
            for (int x = cx * tpecf_pkg::CellSize;
                 x < (cx + 1) * tpecf_pkg::CellSize && x < w; x++) begin
              if (!is_edge(x, y)) continue;
              d2 = (x - px) * (x - px) + (y - py) * (y - py);
              if (d2 < best) begin
                best = d2;
                color = pixel_mem[y * tpecf_pkg::MaxWidth + x][23:0];
              end
            end
        end
      return color;
    endfunction

    function void note_request(logic op, logic [7:0] x, logic [7:0] y, logic [7:0] r,
                               logic [7:0] g, logic [7:0] b, logic [7:0] a);
      bit in_img;
      logic [31:0] p;
      fill_result_t res;
      in_img = x < dim(width_reg) && y < dim(height_reg);
      if (op == tpecf_pkg::OpLoad) begin
        if (!in_img) return;
        pixel_mem[y * tpecf_pkg::MaxWidth + x] = {a, b, g, r};
        if (a != 0 && opaque_total < tpecf_pkg::CountMax) opaque_total++;
        return;
      end
      p = '0;
      if (in_img) begin
        p = pixel_mem[y * tpecf_pkg::MaxWidth + x];
        if (p[31:24] == 0 && opaque_total != 0) p = {8'd0, nearest_color(x, y)};
      end
      res.red = p[7:0];
      res.green = p[15:8];
      res.blue = p[23:16];
      res.alpha = p[31:24];
      res.in_img = in_img;
      pending_q = {pending_q, res};
    endfunction

    task report_mismatch(string what, logic [8:0] got, logic [8:0] want);
      $display("mismatch on %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(fill_result_t got);
      fill_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 9'd0, 9'd0);
        return;
      end
      want = pending_q.pop_front();
      reads_checked++;
      if (got.red !== want.red)
        report_mismatch("red_out", 9'(got.red), 9'(want.red));
      if (got.green !== want.green)
        report_mismatch("green_out", 9'(got.green), 9'(want.green));
      if (got.blue !== want.blue)
        report_mismatch("blue_out", 9'(got.blue), 9'(want.blue));
      if (got.alpha !== want.alpha)
        report_mismatch("alpha_out", 9'(got.alpha), 9'(want.alpha));
      if (got.in_img !== want.in_img)
        report_mismatch("in_range", 9'(got.in_img), 9'(want.in_img));
    endtask
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [8:0] cfg_data;
  logic in_valid, in_ready, operation;
  logic [7:0] x_pos, y_pos, red_in, green_in, blue_in, alpha_in;
  logic out_valid, out_ready;
  logic [7:0] red_out, green_out, blue_out, alpha_out;
  logic in_range;

  fill_scoreboard sb = new();
  int send_gap_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int requests_sent;

  transparent_pixel_edge_color_fill u_top (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // result side
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    fill_result_t res;
    if (!rst && out_valid && out_ready) begin
      res.red = red_out;
      res.green = green_out;
      res.blue = blue_out;
      res.alpha = alpha_out;
      res.in_img = in_range;
      sb.check_result(res);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 1000000) begin
      $display("timeout with %0d reads outstanding", sb.pending_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task write_reg(logic [0:0] idx, logic [8:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task send(logic op, int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b,
            logic [7:0] a);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    x_pos = 8'(x);
    y_pos = 8'(y);
    red_in = r;
    green_in = g;
    blue_in = b;
    alpha_in = a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, 8'(x), 8'(y), r, g, b, a);
    requests_sent++;
  endtask

  task load_rand(int x, int y, int opaque_pct);
    logic [7:0] a;
    a = ($urandom_range(99) < opaque_pct) ? 8'($urandom_range(1, 255)) : 8'd0;
    send(tpecf_pkg::OpLoad, x, y, 8'($urandom), 8'($urandom), 8'($urandom), a);
  endtask

  task read_px(int x, int y);
    send(tpecf_pkg::OpRead, x, y, 8'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom));
  endtask

  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task fill_image(int w, int h, int opaque_pct);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) load_rand(x, y, opaque_pct);
  endtask

  task set_idling(int phase);
    case (phase % 4)
      0: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_gap_pct = 63;
        recv_stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;
        recv_stall_pct = 63;
      end
      default: begin
        send_gap_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  // configure, fill the whole image, then mixed reads and loads
  task run_image(logic [8:0] wreg, logic [8:0] hreg, int opaque_pct, int count);
    int w, h, pick;
    write_reg(tpecf_pkg::RegWidth, wreg);
    write_reg(tpecf_pkg::RegHeight, hreg);
    w = sb.dim(32'(wreg));
    h = sb.dim(32'(hreg));
    fill_image(w, h, opaque_pct);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        read_px($urandom_range(w - 1), $urandom_range(h - 1));
      end else if (pick < 85) begin
        load_rand($urandom_range(w - 1), $urandom_range(h - 1), opaque_pct);
      end else if (w < 256) begin
        if (pick < 95) read_px($urandom_range(w, 255), $urandom_range(255));
        else load_rand($urandom_range(w, 255), $urandom_range(255), 50);
      end else if (h < 256) begin
        if (pick < 95) read_px($urandom_range(255), $urandom_range(h, 255));
        else load_rand($urandom_range(255), $urandom_range(h, 255), 50);
      end else begin
        read_px($urandom_range(w - 1), $urandom_range(h - 1));
      end
    end
    drain();
  endtask

  initial begin
    int w, h;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = tpecf_pkg::RegWidth;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = tpecf_pkg::OpLoad;
    x_pos = '0;
    y_pos = '0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    alpha_in = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    requests_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero sizes act as a single pixel; empty image read returns pixel as is
    write_reg(tpecf_pkg::RegWidth, 9'd0);
    write_reg(tpecf_pkg::RegHeight, 9'd0);
    send(tpecf_pkg::OpLoad, 0, 0, 8'hff, 8'h00, 8'hff, 8'h00);
    read_px(0, 0);
    read_px(255, 255);
    send(tpecf_pkg::OpLoad, 5, 5, 8'h12, 8'h34, 8'h56, 8'hff);
    read_px(0, 0);
    send(tpecf_pkg::OpLoad, 0, 0, 8'h00, 8'hff, 8'h00, 8'hff);
    read_px(0, 0);
    send(tpecf_pkg::OpLoad, 0, 0, 8'h00, 8'hff, 8'h00, 8'hff);
    read_px(0, 0);
    // opaque count is set but no edge pixel exists, so black
    send(tpecf_pkg::OpLoad, 0, 0, 8'haa, 8'h55, 8'haa, 8'h00);
    read_px(0, 0);
    drain();

    // small image with an edge fill
    write_reg(tpecf_pkg::RegWidth, 9'd3);
    write_reg(tpecf_pkg::RegHeight, 9'd2);
    send(tpecf_pkg::OpLoad, 0, 0, 8'h11, 8'h22, 8'h33, 8'h01);
    send(tpecf_pkg::OpLoad, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
    send(tpecf_pkg::OpLoad, 2, 0, 8'hff, 8'hff, 8'hff, 8'hff);
    send(tpecf_pkg::OpLoad, 0, 1, 8'h44, 8'h55, 8'h66, 8'h80);
    send(tpecf_pkg::OpLoad, 1, 1, 8'h77, 8'h88, 8'h99, 8'h00);
    send(tpecf_pkg::OpLoad, 2, 1, 8'h01, 8'h02, 8'h03, 8'h7f);
    read_px(1, 0);
    read_px(1, 1);
    read_px(2, 0);
    read_px(3, 0);
    read_px(0, 2);
    drain();

    // sizes above the maximum clamp to 256
    write_reg(tpecf_pkg::RegWidth, 9'd300);
    write_reg(tpecf_pkg::RegHeight, 9'd511);
    send(tpecf_pkg::OpLoad, 250, 3, 8'h21, 8'h43, 8'h65, 8'h00);
    read_px(250, 3);
    send(tpecf_pkg::OpLoad, 255, 255, 8'h9a, 8'hbc, 8'hde, 8'hf0);
    read_px(255, 255);
    drain();

    // single row image, the row below is outside
    write_reg(tpecf_pkg::RegWidth, 9'd256);
    write_reg(tpecf_pkg::RegHeight, 9'd1);
    send(tpecf_pkg::OpLoad, 3, 1, 8'h01, 8'h02, 8'h03, 8'h04);
    read_px(10, 1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      set_idling(phase);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      run_image(9'(w), 9'(h), (phase == 2) ? 0 : $urandom_range(30, 90), 8);
    end
    send_gap_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("covered %0d requests and %0d checked reads over zero, small, single row",
             requests_sent, sb.reads_checked);
    $display("and clamped image sizes, with sender gaps and result stalls");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
